/* hdl/mstk_pkg.sv */
// package for the kruskal minimum spanning tree unit
// holds sizes, the controller state type and the shared widths; depends on nothing
`timescale 1ns / 1ps

package mstk_pkg;

    localparam int unsigned MAX_VERTICES = 32;
    localparam int unsigned MAX_EDGES    = 256;
    localparam int unsigned WEIGHT_BITS  = 16;
    localparam int unsigned VERT_BITS    = 5;
    localparam int unsigned COST_BITS    = 21;
    localparam int unsigned VCNT_BITS    = 6;

    // configuration register indexes
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_WR,
        ST_SEL_RD,
        ST_SEL_EDGE,
        ST_FIND,
        ST_JOIN,
        ST_EMIT,
        ST_CLOSE,
        ST_CLEAR
    } mstk_state_t;

endpackage

/* hdl/mstk_stream_if.sv */
// valid/ready stream interfaces for the kruskal unit channels
// depends on mstk_pkg for field widths
`timescale 1ns / 1ps

interface mstk_edge_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    is_edge;
    logic [mstk_pkg::VERT_BITS-1:0]          src_vertex;
    logic [mstk_pkg::VERT_BITS-1:0]          dst_vertex;
    logic signed [mstk_pkg::WEIGHT_BITS-1:0] weight;
    logic                                    last_edge;

    modport source (output valid, is_edge, src_vertex, dst_vertex, weight, last_edge,
                    input ready);
    modport sink (input valid, is_edge, src_vertex, dst_vertex, weight, last_edge,
                  output ready);
endinterface

interface mstk_tree_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    is_tree_edge;
    logic [mstk_pkg::VERT_BITS-1:0]          end_a;
    logic [mstk_pkg::VERT_BITS-1:0]          end_b;
    logic signed [mstk_pkg::WEIGHT_BITS-1:0] edge_weight;
    logic signed [mstk_pkg::COST_BITS-1:0]   total_cost;
    logic                                    edges_dropped;
    logic                                    last;

    modport source (output valid, is_tree_edge, end_a, end_b, edge_weight, total_cost,
                    edges_dropped, last, input ready);
    modport sink (input valid, is_tree_edge, end_a, end_b, edge_weight, total_cost,
                  edges_dropped, last, output ready);
endinterface

/* hdl/minimum_spanning_tree_kruskal_unit.sv */
// Edges stream in one per cycle into an edge memory and are held there until the item
// marked last_edge arrives. The unit then insertion-sorts the memory in place (stable,
// ascending weight); this read-compare-write loop on the edge memory sets the run time.
// Selection then reads the sorted edges in order, until one fewer than the vertex count
// have been chosen, and walks both endpoints to their roots in the parent memory, one
// parent read per cycle, then writes one link and emits a transfer for every chosen edge,
// followed by a closing record with the cost sum. A clearing pass over all MAX_VERTICES
// entries restores the parent memory before the next graph is accepted. Input items are
// refused from the last_edge transfer until that pass ends.
// Depends on mstk_pkg and the stream interfaces.
`timescale 1ns / 1ps

module minimum_spanning_tree_kruskal_unit #(
    parameter int unsigned MAX_VERTICES = mstk_pkg::MAX_VERTICES,
    parameter int unsigned MAX_EDGES    = mstk_pkg::MAX_EDGES
) (
    input  logic        clk,
    input  logic        rst_n,
    mstk_edge_if.sink   in_edge,
    mstk_tree_if.source out_tree,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned VB = mstk_pkg::VERT_BITS;
    localparam int unsigned WB = mstk_pkg::WEIGHT_BITS;
    localparam int unsigned CB = mstk_pkg::COST_BITS;
    localparam int unsigned AB = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int unsigned CNTB = AB + 1;
    localparam int unsigned PB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned SB = PB + 1;
    localparam int unsigned EW = 2 * VB + WB;

    typedef struct packed {
        logic [VB-1:0]        a;
        logic [VB-1:0]        b;
        logic signed [WB-1:0] w;
    } edge_t;

    // configuration register
    logic [mstk_pkg::VCNT_BITS-1:0] vertex_count_reg;
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_count_reg <= mstk_pkg::VCNT_BITS'(32);
        else if (cfg_wr && (paddr[1:1] == mstk_pkg::REG_VERTEX_COUNT))
            vertex_count_reg <= pwdata[mstk_pkg::VCNT_BITS-1:0];
    end
    always_comb
    begin
        prdata = '0;
        if (paddr[1:1] == mstk_pkg::REG_VERTEX_COUNT)
            prdata[mstk_pkg::VCNT_BITS-1:0] = vertex_count_reg;
    end

    // effective vertex count and edge limit
    logic [mstk_pkg::VCNT_BITS-1:0] vcount;
    logic [mstk_pkg::VCNT_BITS-1:0] limit;
    always_comb
    begin
        if (32'(vertex_count_reg) > MAX_VERTICES)
            vcount = mstk_pkg::VCNT_BITS'(MAX_VERTICES);
        else
            vcount = vertex_count_reg;
        limit = (vcount == '0) ? '0 : vcount - 1'b1;
    end

    // edge memory and parent memory, both with registered reads
    logic [EW-1:0] emem [MAX_EDGES];
    logic [PB-1:0] pmem [MAX_VERTICES];
    logic          e_we;
    logic [AB-1:0] e_waddr, e_raddr;
    edge_t         e_wdata;
    logic [EW-1:0] e_rdata;
    logic          p_we;
    logic [PB-1:0] p_waddr, p_raddr;
    logic [PB-1:0] p_wdata, p_rdata;
    logic [PB-1:0] p_raddr_q;

    always_ff @(posedge clk)
    begin
        if (e_we)
            emem[e_waddr] <= e_wdata;
        e_rdata <= emem[e_raddr];
    end
    always_ff @(posedge clk)
    begin
        if (p_we)
            pmem[p_waddr] <= p_wdata;
        p_rdata <= pmem[p_raddr];
    end

    edge_t e_rd;
    assign e_rd = edge_t'(e_rdata);

    // control and datapath registers
    mstk_pkg::mstk_state_t state_reg, state_next;
    logic [CNTB-1:0] count_reg, count_next;
    logic [CNTB-1:0] i_reg, i_next;
    logic [CNTB-1:0] j_reg, j_next;
    edge_t           cur_reg, cur_next;
    logic [PB-1:0]   ra_reg, ra_next, rb_reg, rb_next;
    logic            side_reg, side_next;
    logic [SB-1:0]   steps_reg, steps_next;
    logic [VB-1:0]   chosen_reg, chosen_next;
    logic signed [CB-1:0] cost_reg, cost_next;
    logic            ovf_reg, ovf_next;
    logic [PB-1:0]   clr_reg, clr_next;
    logic            ov_reg, ov_next;
    logic            otree_reg, otree_next, olast_reg, olast_next;
    edge_t           oedge_reg, oedge_next;
    logic signed [CB-1:0] ocost_reg, ocost_next;
    logic            odrop_reg, odrop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mstk_pkg::ST_CLEAR;
            count_reg  <= '0;
            chosen_reg <= '0;
            cost_reg   <= '0;
            ovf_reg    <= 1'b0;
            clr_reg    <= '0;
            ov_reg     <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            side_reg   <= 1'b0;
            steps_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            chosen_reg <= chosen_next;
            cost_reg   <= cost_next;
            ovf_reg    <= ovf_next;
            clr_reg    <= clr_next;
            ov_reg     <= ov_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            side_reg   <= side_next;
            steps_reg  <= steps_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        otree_reg <= otree_next;
        olast_reg <= olast_next;
        oedge_reg <= oedge_next;
        ocost_reg <= ocost_next;
        odrop_reg <= odrop_next;
    end

    logic in_xfer, out_xfer, in_ok;
    logic [PB-1:0] node;
    assign in_xfer  = in_edge.valid && in_edge.ready;
    assign out_xfer = ov_reg && out_tree.ready;
    assign in_ok    = in_edge.is_edge && (6'(in_edge.src_vertex) < vcount)
                      && (6'(in_edge.dst_vertex) < vcount);
    // current node of a root walk: vertex on the first step, else the parent just read
    assign node = (steps_reg == '0) ? (side_reg ? PB'(cur_reg.b) : PB'(cur_reg.a))
                                    : p_rdata;

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        cur_next    = cur_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        side_next   = side_reg;
        steps_next  = steps_reg;
        chosen_next = chosen_reg;
        cost_next   = cost_reg;
        ovf_next    = ovf_reg;
        clr_next    = clr_reg;
        ov_next     = ov_reg;
        otree_next  = otree_reg;
        olast_next  = olast_reg;
        oedge_next  = oedge_reg;
        ocost_next  = ocost_reg;
        odrop_next  = odrop_reg;
        e_we        = 1'b0;
        e_waddr     = j_reg[AB-1:0];
        e_wdata     = cur_reg;
        e_raddr     = i_reg[AB-1:0];
        p_we        = 1'b0;
        p_waddr     = clr_reg;
        p_wdata     = clr_reg;
        p_raddr     = node;
        in_edge.ready = 1'b0;

        if (out_xfer)
            ov_next = 1'b0;

        case (state_reg)
            mstk_pkg::ST_CLEAR:
            begin
                // restore every vertex as its own parent
                p_we     = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_VERTICES - 1)
                begin
                    clr_next   = '0;
                    state_next = mstk_pkg::ST_LOAD;
                end
            end
            mstk_pkg::ST_LOAD:
            begin
                in_edge.ready = 1'b1;
                e_waddr = count_reg[AB-1:0];
                e_wdata = '{a: in_edge.src_vertex, b: in_edge.dst_vertex,
                            w: in_edge.weight};
                if (in_xfer)
                begin
                    if (in_ok)
                    begin
                        if (32'(count_reg) < MAX_EDGES)
                        begin
                            e_we       = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    if (in_edge.last_edge)
                    begin
                        i_next     = CNTB'(1);
                        state_next = mstk_pkg::ST_SORT_RD;
                    end
                end
            end
            mstk_pkg::ST_SORT_RD:
            begin
                // fetch entry i for insertion
                e_raddr   = i_reg[AB-1:0];
                side_next = 1'b0;
                if (i_reg >= count_next)
                begin
                    i_next     = '0;
                    state_next = mstk_pkg::ST_SEL_RD;
                end
                else
                begin
                    j_next     = i_reg;
                    state_next = mstk_pkg::ST_SORT_CMP;
                end
            end
            mstk_pkg::ST_SORT_CMP:
            begin
                // first cycle after the fetch captures the edge being inserted
                if (j_reg == i_reg && !side_reg)
                begin
                    cur_next  = e_rd;
                    side_next = 1'b1;
                    e_raddr   = AB'(j_reg - 1'b1);
                    if (j_reg == '0)
                    begin
                        side_next  = 1'b0;
                        state_next = mstk_pkg::ST_SORT_WR;
                    end
                end
                else
                begin
                    // e_rd holds entry j-1
                    if (e_rd.w > cur_reg.w)
                    begin
                        e_we    = 1'b1;
                        e_waddr = j_reg[AB-1:0];
                        e_wdata = e_rd;
                        j_next  = j_reg - 1'b1;
                        e_raddr = AB'(j_reg - 2'd2);
                        if (j_reg == CNTB'(1))
                        begin
                            side_next  = 1'b0;
                            state_next = mstk_pkg::ST_SORT_WR;
                        end
                    end
                    else
                    begin
                        side_next  = 1'b0;
                        state_next = mstk_pkg::ST_SORT_WR;
                    end
                end
            end
            mstk_pkg::ST_SORT_WR:
            begin
                e_we       = 1'b1;
                e_waddr    = j_reg[AB-1:0];
                e_wdata    = cur_reg;
                i_next     = i_reg + 1'b1;
                state_next = mstk_pkg::ST_SORT_RD;
            end
            mstk_pkg::ST_SEL_RD:
            begin
                e_raddr = i_reg[AB-1:0];
                if (i_reg >= count_reg || 6'(chosen_reg) >= limit)
                    state_next = mstk_pkg::ST_CLOSE;
                else
                    state_next = mstk_pkg::ST_SEL_EDGE;
            end
            mstk_pkg::ST_SEL_EDGE:
            begin
                cur_next   = e_rd;
                side_next  = 1'b0;
                steps_next = '0;
                state_next = mstk_pkg::ST_FIND;
            end
            mstk_pkg::ST_FIND:
            begin
                // one parent read per cycle; p_rdata holds parent of the previous node
                if (steps_reg != '0 && (p_rdata == p_raddr_q || 32'(steps_reg) > MAX_VERTICES))
                begin
                    if (!side_reg)
                    begin
                        ra_next    = p_raddr_q;
                        side_next  = 1'b1;
                        steps_next = '0;
                        p_raddr    = PB'(cur_reg.b);
                    end
                    else
                    begin
                        rb_next    = p_raddr_q;
                        state_next = mstk_pkg::ST_JOIN;
                    end
                end
                else
                    steps_next = steps_reg + 1'b1;
            end
            mstk_pkg::ST_JOIN:
            begin
                i_next = i_reg + 1'b1;
                if (ra_reg != rb_reg)
                begin
                    p_we        = 1'b1;
                    p_waddr     = ra_reg;
                    p_wdata     = rb_reg;
                    chosen_next = chosen_reg + 1'b1;
                    cost_next   = cost_reg + CB'(cur_reg.w);
                    state_next  = mstk_pkg::ST_EMIT;
                end
                else
                    state_next = mstk_pkg::ST_SEL_RD;
            end
            mstk_pkg::ST_EMIT:
            begin
                if (!ov_reg || out_xfer)
                begin
                    ov_next    = 1'b1;
                    otree_next = 1'b1;
                    olast_next = 1'b0;
                    oedge_next = cur_reg;
                    ocost_next = cost_reg;
                    odrop_next = ovf_reg;
                    state_next = mstk_pkg::ST_SEL_RD;
                end
            end
            mstk_pkg::ST_CLOSE:
            begin
                if (!ov_reg || out_xfer)
                begin
                    ov_next     = 1'b1;
                    otree_next  = 1'b0;
                    olast_next  = 1'b1;
                    oedge_next  = '0;
                    ocost_next  = cost_reg;
                    odrop_next  = ovf_reg;
                    count_next  = '0;
                    chosen_next = '0;
                    cost_next   = '0;
                    ovf_next    = 1'b0;
                    i_next      = '0;
                    state_next  = mstk_pkg::ST_CLEAR;
                end
            end
            default:
                state_next = mstk_pkg::ST_CLEAR;
        endcase
    end

    // node whose parent is now in p_rdata
    always_ff @(posedge clk)
    begin
        p_raddr_q <= p_raddr;
    end

    // result channel
    assign out_tree.valid         = ov_reg;
    assign out_tree.is_tree_edge  = otree_reg;
    assign out_tree.end_a         = oedge_reg.a;
    assign out_tree.end_b         = oedge_reg.b;
    assign out_tree.edge_weight   = oedge_reg.w;
    assign out_tree.total_cost    = ocost_reg;
    assign out_tree.edges_dropped = odrop_reg;
    assign out_tree.last          = olast_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_edge.ready |-> state_reg == mstk_pkg::ST_LOAD)
        else $error("input accepted outside load");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= MAX_EDGES)
        else $error("edge count beyond capacity");
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && olast_reg) |-> chosen_reg == '0 || state_reg != mstk_pkg::ST_LOAD)
        else $error("run not cleared after closing record");
    a_chosen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        6'(chosen_reg) <= limit || state_reg == mstk_pkg::ST_LOAD)
        else $error("more tree edges than vertices allow");

endmodule

/* test/tb_minimum_spanning_tree_kruskal_unit.sv */
// testbench for minimum_spanning_tree_kruskal_unit: streams graphs in, predicts the spanning
// forest records and checks every output transfer against them
// depends on mstk_pkg, the stream interfaces and the unit itself
`timescale 1ns / 1ps

module tb_minimum_spanning_tree_kruskal_unit;

    localparam int unsigned MAX_VERTICES   = mstk_pkg::MAX_VERTICES;
    localparam int unsigned MAX_EDGES      = mstk_pkg::MAX_EDGES;
    localparam int unsigned VERT_BITS      = mstk_pkg::VERT_BITS;
    localparam int unsigned WEIGHT_BITS    = mstk_pkg::WEIGHT_BITS;
    localparam int unsigned COST_BITS      = mstk_pkg::COST_BITS;
    localparam int unsigned VCNT_BITS      = mstk_pkg::VCNT_BITS;
    localparam int unsigned WATCHDOG_LIMIT = 400000;
    localparam int unsigned CLEAR_WAIT     = 2 * MAX_VERTICES + 16;
    localparam int unsigned HOLD_CYCLES    = 500;

    typedef struct packed {
        logic [VERT_BITS-1:0]          a;
        logic [VERT_BITS-1:0]          b;
        logic signed [WEIGHT_BITS-1:0] w;
    } graph_edge_t;

    typedef struct packed {
        logic                          is_tree_edge;
        logic [VERT_BITS-1:0]          end_a;
        logic [VERT_BITS-1:0]          end_b;
        logic signed [WEIGHT_BITS-1:0] edge_weight;
        logic signed [COST_BITS-1:0]   total_cost;
        logic                          edges_dropped;
        logic                          last;
    } tree_rec_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mstk_edge_if edge_ch ();
    mstk_tree_if tree_ch ();

    minimum_spanning_tree_kruskal_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_edge  (edge_ch),
        .out_tree (tree_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    graph_edge_t held_edges[$];
    logic [VCNT_BITS-1:0] vertex_limit_reg;
    logic                 dropped_flag;
    tree_rec_t            expected_recs[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          holding;
    event        hold_off_ev;
    int unsigned items_sent;
    int unsigned graphs_sent;
    int unsigned recs_checked;
    int unsigned error_count;
    int unsigned quiet_cycles;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // forest prediction for one accepted input item
    function automatic void absorb_item(logic is_edge, logic [VERT_BITS-1:0] src,
                                        logic [VERT_BITS-1:0] dst,
                                        logic signed [WEIGHT_BITS-1:0] w, logic last_edge);
        int unsigned vc;
        int unsigned limit;
        int unsigned chosen;
        int unsigned ra;
        int unsigned rb;
        int unsigned steps;
        int          j;
        graph_edge_t cur;
        graph_edge_t ge;
        logic [VERT_BITS-1:0] parent[MAX_VERTICES];
        logic signed [COST_BITS-1:0] cost;
        tree_rec_t rec;
        vc = (vertex_limit_reg > MAX_VERTICES) ? MAX_VERTICES : vertex_limit_reg;
        if (is_edge && src < vc && dst < vc)
        begin
            if (held_edges.size() < MAX_EDGES)
            begin
                ge = '{src, dst, w};
                held_edges = {held_edges, ge};
            end
            else
                dropped_flag = 1'b1;
        end
        if (!last_edge)
            return;
        // stable insertion sort by weight
        for (int i = 1; i < held_edges.size(); i++)
        begin
            cur = held_edges[i];
            j = i;
            while (j > 0 && held_edges[j-1].w > cur.w)
            begin
                held_edges[j] = held_edges[j-1];
                j--;
            end
            held_edges[j] = cur;
        end
        for (int v = 0; v < MAX_VERTICES; v++)
            parent[v] = VERT_BITS'(v);
        limit  = (vc == 0) ? 0 : vc - 1;
        chosen = 0;
        cost   = '0;
        foreach (held_edges[i])
        begin
            if (chosen >= limit)
                break;
            ge = held_edges[i];
            ra = ge.a;
            steps = 0;
            while (parent[ra] != ra && steps < MAX_VERTICES)
            begin
                ra = parent[ra];
                steps++;
            end
            rb = ge.b;
            steps = 0;
            while (parent[rb] != rb && steps < MAX_VERTICES)
            begin
                rb = parent[rb];
                steps++;
            end
            if (ra != rb)
            begin
                parent[ra] = VERT_BITS'(rb);
                chosen++;
                cost = cost + COST_BITS'(ge.w);
                rec = '{1'b1, ge.a, ge.b, ge.w, cost, dropped_flag, 1'b0};
                expected_recs = {expected_recs, rec};
            end
        end
        rec = '{1'b0, '0, '0, '0, cost, dropped_flag, 1'b1};
        expected_recs = {expected_recs, rec};
        held_edges.delete();
        dropped_flag = 1'b0;
        graphs_sent++;
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(logic is_edge, logic [VERT_BITS-1:0] src,
                             logic [VERT_BITS-1:0] dst, logic signed [WEIGHT_BITS-1:0] w,
                             logic last_edge);
        while ($urandom_range(99) < send_idle_pct)
        begin
            edge_ch.valid <= 1'b0;
            @(posedge clk);
        end
        edge_ch.valid      <= 1'b1;
        edge_ch.is_edge    <= is_edge;
        edge_ch.src_vertex <= src;
        edge_ch.dst_vertex <= dst;
        edge_ch.weight     <= w;
        edge_ch.last_edge  <= last_edge;
        @(posedge clk);
        while (!edge_ch.ready)
            @(posedge clk);
        absorb_item(is_edge, src, dst, w, last_edge);
        items_sent++;
    endtask

    task automatic go_quiet();
        edge_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for all records and the clearing pass before touching the register
    task automatic drain();
        go_quiet();
        wait (expected_recs.size() == 0);
        repeat (CLEAR_WAIT) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 2'(mstk_pkg::REG_VERTEX_COUNT) << 2;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vertex_limit_reg = value[VCNT_BITS-1:0];
    endtask

    // one graph of n items with mostly in-range endpoints and some noise
    task automatic send_random_graph(int unsigned n);
        int unsigned vc;
        int unsigned r;
        logic [VERT_BITS-1:0] a;
        logic [VERT_BITS-1:0] b;
        vc = (vertex_limit_reg > MAX_VERTICES) ? MAX_VERTICES : vertex_limit_reg;
        for (int unsigned k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 10 || vc == 0)
            begin
                a = VERT_BITS'($urandom_range(31));
                b = VERT_BITS'($urandom_range(31));
            end
            else
            begin
                a = VERT_BITS'($urandom_range(vc - 1));
                b = VERT_BITS'($urandom_range(vc - 1));
            end
            // small weight range gives ties, full range reaches every bit
            send_item(r >= 5, a, b,
                      (r < 50) ? WEIGHT_BITS'($urandom_range(7)) : WEIGHT_BITS'($urandom),
                      k == n - 1);
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // extremes of weight, ties in arrival order, self loop, marker items
        send_item(1'b1, 5'd0, 5'd31, 16'sh7fff, 1'b0);
        send_item(1'b1, 5'd31, 5'd0, 16'sh8000, 1'b0);
        send_item(1'b1, 5'd3, 5'd3, -16'sd40, 1'b0);
        send_item(1'b0, 5'd31, 5'd31, 16'shffff, 1'b0);
        send_item(1'b1, 5'd1, 5'd2, 16'sd5, 1'b0);
        send_item(1'b1, 5'd2, 5'd1, 16'sd5, 1'b0);
        send_item(1'b1, 5'd1, 5'd0, 16'sd5, 1'b0);
        send_item(1'b1, 5'd21, 5'd10, 16'sd0, 1'b0);
        send_item(1'b0, 5'd0, 5'd0, 16'sd0, 1'b1);
        // small graph with endpoints out of range
        write_vertex_count(32'd4);
        send_item(1'b1, 5'd0, 5'd4, 16'sd1, 1'b0);
        send_item(1'b1, 5'd31, 5'd1, 16'sd1, 1'b0);
        send_item(1'b1, 5'd0, 5'd1, 16'sd9, 1'b0);
        send_item(1'b1, 5'd1, 5'd2, 16'sd8, 1'b0);
        send_item(1'b1, 5'd2, 5'd3, 16'sd7, 1'b0);
        send_item(1'b1, 5'd3, 5'd0, 16'sd1, 1'b1);
        // zero vertices: closing record only
        write_vertex_count(32'd0);
        send_item(1'b1, 5'd0, 5'd0, 16'sd3, 1'b0);
        send_item(1'b1, 5'd0, 5'd1, 16'sd3, 1'b1);
        // one vertex: no edge can be chosen
        write_vertex_count(32'd1);
        send_item(1'b1, 5'd0, 5'd0, 16'sd3, 1'b1);
        // count above the vertex limit is clipped
        write_vertex_count(32'd63);
        send_item(1'b1, 5'd30, 5'd31, -16'sd2, 1'b0);
        send_item(1'b1, 5'd31, 5'd30, -16'sd3, 1'b1);
        write_vertex_count(32'd32);
    endtask

    // more edges than the store holds
    task automatic test_store_full();
        for (int unsigned k = 0; k < MAX_EDGES + 3; k++)
            send_item(1'b1, 5'($urandom_range(31)), 5'($urandom_range(31)),
                      WEIGHT_BITS'($urandom), k == MAX_EDGES + 2);
        send_random_graph(6);
    endtask

    task automatic test_random_phases();
        int unsigned phase_target;
        int unsigned pick;
        for (int unsigned ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 82 : (ph == 3) ? 23 : 0;
            recv_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 23 : 0;
            phase_target = items_sent + 12;
            while (items_sent < phase_target)
            begin
                if ($urandom_range(99) < 25)
                begin
                    pick = $urandom_range(5);
                    write_vertex_count(pick == 0 ? 32'd1 : pick == 1 ? 32'd2 :
                                       pick == 2 ? 32'd32 : pick == 3 ? 32'd0 :
                                       pick == 4 ? 32'($urandom_range(33, 63)) :
                                       32'($urandom_range(3, 31)));
                end
                send_random_graph($urandom_range(1, 14));
            end
        end
        write_vertex_count(32'd32);
    endtask

    // receiver holds off while graphs keep coming, so input gets refused
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_off_ev;
        for (int unsigned g = 0; g < 4; g++)
            send_random_graph($urandom_range(3, 10));
    endtask

    // long receiver hold-off, counted here
    always @(hold_off_ev)
    begin
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    // output check and receiver ready
    always @(posedge clk)
    begin
        tree_rec_t got;
        tree_rec_t want;
        if (rst_n && tree_ch.valid && tree_ch.ready)
        begin
            got = '{tree_ch.is_tree_edge, tree_ch.end_a, tree_ch.end_b, tree_ch.edge_weight,
                    tree_ch.total_cost, tree_ch.edges_dropped, tree_ch.last};
            recs_checked++;
            if (expected_recs.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer %p", $time, got);
            end
            else
            begin
                want = expected_recs.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: record mismatch expected %p actual %p", $time, want, got);
                end
            end
        end
        tree_ch.ready <= !holding && ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((edge_ch.valid && edge_ch.ready) || (tree_ch.valid && tree_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        edge_ch.valid      = 1'b0;
        edge_ch.is_edge    = 1'b0;
        edge_ch.src_vertex = '0;
        edge_ch.dst_vertex = '0;
        edge_ch.weight     = '0;
        edge_ch.last_edge  = 1'b0;
        tree_ch.ready      = 1'b0;
        holding            = 1'b0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        items_sent         = 0;
        graphs_sent        = 0;
        recs_checked       = 0;
        error_count        = 0;
        quiet_cycles       = 0;
        vertex_limit_reg   = 6'd32;
        dropped_flag       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (MAX_VERTICES + 4) @(posedge clk);

        test_directed();
        test_store_full();
        test_random_phases();
        test_backpressure();

        drain();
        $display("covered %0d input items in %0d graphs, %0d output records checked",
                 items_sent, graphs_sent, recs_checked);
        $display("vertex counts 0 to 63, store overflow, ties, self loops and stalls");
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
